### src/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Delta timer queue package
// Shared sizes, opcode and status codes, beat structs and the controller to
// datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    localparam int TIMERS     = 16;
    localparam int DELTA_BITS = 32;
    localparam int NHANDLES   = 16;
    localparam int HANDLE_W   = 4;
    localparam int EXP_W      = 32;
    localparam int COUNT_W    = $clog2(TIMERS + 1);
    localparam int IDX_W      = $clog2(TIMERS);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BAD_ADD   = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOT_QUEUED = 3'd4;
    localparam logic [2:0] ST_EXPIRED   = 3'd5;
    localparam logic [2:0] ST_TICK_NONE = 3'd6;

    localparam logic [1:0] HSEL_ITEM = 2'd0;
    localparam logic [1:0] HSEL_HEAD = 2'd1;
    localparam logic [1:0] HSEL_NONE = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [HANDLE_W-1:0] timer_handle;
        logic [EXP_W-1:0]    expiry_ticks;
    } dtq_in_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] handle_out;
        logic                last;
    } dtq_out_t;

    typedef struct packed {
        logic       load;
        logic       dec_head;
        logic       walk;
        logic       step;
        logic       insert;
        logic       remove;
        logic       pop;
        logic       emit;
        logic [2:0] status;
        logic [1:0] hsel;
        logic       last;
    } dtq_cmd_t;

    typedef struct packed {
        logic zero_expiry;
        logic queued;
        logic full;
        logic at_end;
        logic add_here;
        logic found;
        logic head_expire;
        logic expire_last;
    } dtq_stat_t;

    function automatic logic [DELTA_BITS-1:0] sat_delta(input logic [EXP_W-1:0] e);
        logic [63:0] ew;
        logic [63:0] dmask;
        ew    = 64'(e);
        dmask = {64{1'b1}} >> (64 - DELTA_BITS);
        return (ew > dmask) ? DELTA_BITS'(dmask) : DELTA_BITS'(ew);
    endfunction

endpackage

`default_nettype wire

### src/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// Delta timer queue controller
// Sequences add, delete and tick operations and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          opcode,
    input  wire dtq_pkg::dtq_stat_t  stat,
    output logic                     busy,
    output dtq_pkg::dtq_cmd_t        ctl
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_CHK  = 3'd1;
    localparam logic [2:0] S_ADD_WALK = 3'd2;
    localparam logic [2:0] S_DELETE   = 3'd3;
    localparam logic [2:0] S_TICK     = 3'd4;
    localparam logic [2:0] S_EXPIRE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    case (opcode)
                        dtq_pkg::OP_ADD:    state_next = S_ADD_CHK;
                        dtq_pkg::OP_DELETE: state_next = S_DELETE;
                        dtq_pkg::OP_TICK:   state_next = S_TICK;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_CHK:
            begin
                if (stat.zero_expiry || stat.queued)
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = dtq_pkg::ST_BAD_ADD;
                    ctl.hsel   = dtq_pkg::HSEL_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.full)
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = dtq_pkg::ST_FULL;
                    ctl.hsel   = dtq_pkg::HSEL_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADD_WALK;
                end
            end
            S_ADD_WALK:
            begin
                if (stat.at_end || stat.add_here)
                begin
                    ctl.insert = 1'b1;
                    ctl.emit   = 1'b1;
                    ctl.status = dtq_pkg::ST_ADDED;
                    ctl.hsel   = dtq_pkg::HSEL_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.walk = 1'b1;
                end
            end
            S_DELETE:
            begin
                if (!stat.queued)
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = dtq_pkg::ST_NOT_QUEUED;
                    ctl.hsel   = dtq_pkg::HSEL_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.at_end || stat.found)
                begin
                    ctl.remove = !stat.at_end;
                    ctl.emit   = 1'b1;
                    ctl.status = dtq_pkg::ST_DELETED;
                    ctl.hsel   = dtq_pkg::HSEL_ITEM;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            S_TICK:
            begin
                ctl.dec_head = 1'b1;
                state_next   = S_EXPIRE;
            end
            S_EXPIRE:
            begin
                ctl.emit = 1'b1;
                if (stat.head_expire)
                begin
                    ctl.remove = 1'b1;
                    ctl.pop    = 1'b1;
                    ctl.status = dtq_pkg::ST_EXPIRED;
                    ctl.hsel   = dtq_pkg::HSEL_HEAD;
                    ctl.last   = stat.expire_last;
                    if (stat.expire_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.status = dtq_pkg::ST_TICK_NONE;
                    ctl.hsel   = dtq_pkg::HSEL_NONE;
                    ctl.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/dtq_datapath.sv
// ----------------------------------------------------------------------------
// Delta timer queue datapath
// Holds the ordered queue of handles and deltas, the queued flags, the walk
// index and remaining expiry, and the registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dtq_pkg::dtq_in_t   cmd,
    input  wire dtq_pkg::dtq_cmd_t  ctl,
    output dtq_pkg::dtq_stat_t      stat,
    output dtq_pkg::dtq_out_t       result,
    output logic                    result_valid
);

    logic [dtq_pkg::HANDLE_W-1:0]   handles_reg  [dtq_pkg::TIMERS];
    logic [dtq_pkg::HANDLE_W-1:0]   handles_next [dtq_pkg::TIMERS];
    logic [dtq_pkg::DELTA_BITS-1:0] deltas_reg   [dtq_pkg::TIMERS];
    logic [dtq_pkg::DELTA_BITS-1:0] deltas_next  [dtq_pkg::TIMERS];
    logic [dtq_pkg::COUNT_W-1:0]    count_reg;
    logic [dtq_pkg::COUNT_W-1:0]    count_next;
    logic [dtq_pkg::NHANDLES-1:0]   flags_reg;
    logic [dtq_pkg::NHANDLES-1:0]   flags_next;
    logic [dtq_pkg::HANDLE_W-1:0]   h_reg;
    logic [dtq_pkg::HANDLE_W-1:0]   h_next;
    logic [dtq_pkg::DELTA_BITS-1:0] e_reg;
    logic [dtq_pkg::DELTA_BITS-1:0] e_next;
    logic [dtq_pkg::COUNT_W-1:0]    p_reg;
    logic [dtq_pkg::COUNT_W-1:0]    p_next;
    dtq_pkg::dtq_out_t              result_reg;
    dtq_pkg::dtq_out_t              result_next;
    logic                           result_valid_reg;
    logic                           result_valid_next;

    logic [dtq_pkg::IDX_W-1:0]      p_idx;
    logic [dtq_pkg::COUNT_W-1:0]    rm_pos;
    logic [dtq_pkg::COUNT_W-1:0]    p_plus1;
    logic [dtq_pkg::HANDLE_W-1:0]   clr_handle;

    assign p_idx      = p_reg[dtq_pkg::IDX_W-1:0];
    assign rm_pos     = ctl.pop ? '0 : p_reg;
    assign p_plus1    = p_reg + dtq_pkg::COUNT_W'(1);
    assign clr_handle = ctl.pop ? handles_reg[0] : h_reg;

    assign stat.zero_expiry = (e_reg == '0);
    assign stat.queued      = flags_reg[h_reg];
    assign stat.full        = (count_reg == dtq_pkg::COUNT_W'(dtq_pkg::TIMERS));
    assign stat.at_end      = (p_reg == count_reg);
    assign stat.add_here    = (e_reg < deltas_reg[p_idx]);
    assign stat.found       = (handles_reg[p_idx] == h_reg);
    assign stat.head_expire = (count_reg != '0) && (deltas_reg[0] == '0);
    assign stat.expire_last = (count_reg == dtq_pkg::COUNT_W'(1)) || (deltas_reg[1] != '0);

    always_comb
    begin
        for (int j = 0; j < dtq_pkg::TIMERS; j++)
        begin
            handles_next[j] = handles_reg[j];
            deltas_next[j]  = deltas_reg[j];
            if (ctl.dec_head && (j == 0) && (count_reg != '0) && (deltas_reg[0] != '0))
            begin
                deltas_next[j] = deltas_reg[j] - dtq_pkg::DELTA_BITS'(1);
            end
            if (ctl.insert)
            begin
                if (dtq_pkg::COUNT_W'(j) > p_reg)
                begin
                    handles_next[j] = handles_reg[(j == 0) ? 0 : j - 1];
                    deltas_next[j]  = deltas_reg[(j == 0) ? 0 : j - 1];
                    if (dtq_pkg::COUNT_W'(j) == p_plus1)
                    begin
                        deltas_next[j] = deltas_reg[(j == 0) ? 0 : j - 1] - e_reg;
                    end
                end
                else if (dtq_pkg::COUNT_W'(j) == p_reg)
                begin
                    handles_next[j] = h_reg;
                    deltas_next[j]  = e_reg;
                end
            end
            if (ctl.remove && (dtq_pkg::COUNT_W'(j) >= rm_pos) && (j < dtq_pkg::TIMERS - 1))
            begin
                handles_next[j] = handles_reg[(j == dtq_pkg::TIMERS - 1) ? j : j + 1];
                deltas_next[j]  = deltas_reg[(j == dtq_pkg::TIMERS - 1) ? j : j + 1];
                if (dtq_pkg::COUNT_W'(j) == rm_pos)
                begin
                    deltas_next[j] = deltas_reg[(j == dtq_pkg::TIMERS - 1) ? j : j + 1]
                                     + deltas_reg[j];
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        flags_next = flags_reg;
        h_next     = h_reg;
        e_next     = e_reg;
        p_next     = p_reg;
        if (ctl.load)
        begin
            h_next = cmd.timer_handle;
            e_next = dtq_pkg::sat_delta(cmd.expiry_ticks);
            p_next = '0;
        end
        if (ctl.walk)
        begin
            e_next = e_reg - deltas_reg[p_idx];
            p_next = p_plus1;
        end
        if (ctl.step)
        begin
            p_next = p_plus1;
        end
        if (ctl.insert)
        begin
            count_next        = count_reg + dtq_pkg::COUNT_W'(1);
            flags_next[h_reg] = 1'b1;
        end
        if (ctl.remove)
        begin
            count_next             = count_reg - dtq_pkg::COUNT_W'(1);
            flags_next[clr_handle] = 1'b0;
        end
        if (!ctl.remove && ctl.emit && (ctl.status == dtq_pkg::ST_DELETED))
        begin
            flags_next[h_reg] = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = ctl.emit;
        result_next       = result_reg;
        if (ctl.emit)
        begin
            result_next.status = ctl.status;
            result_next.last   = ctl.last;
            case (ctl.hsel)
                dtq_pkg::HSEL_ITEM: result_next.handle_out = h_reg;
                dtq_pkg::HSEL_HEAD: result_next.handle_out = handles_reg[0];
                default:            result_next.handle_out = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < dtq_pkg::TIMERS; j++)
        begin
            handles_reg[j] <= handles_next[j];
            deltas_reg[j]  <= deltas_next[j];
        end
        h_reg      <= h_next;
        e_reg      <= e_next;
        p_reg      <= p_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            flags_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            flags_reg        <= flags_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

### src/delta_timer_queue_core.sv
// ----------------------------------------------------------------------------
// Delta timer queue core
// Timer queue sorted by expiry, each entry holding its delta from the one
// before it. Supports add, delete and tick with one result beat per event.
// ----------------------------------------------------------------------------
// Add: a reject from the check state, or else a walk to the insert point.
// Delete: a not-queued reject, or else a search of the queue entry by entry.
// Tick: the head delta is decremented, then the result beats, one per cycle.
// One command at a time; busy falls as the last beat is shown.
// Reset empties the queue at once; results cannot be held off by the receiver.
`default_nettype none

module delta_timer_queue_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dtq_pkg::dtq_in_t  cmd,
    output dtq_pkg::dtq_out_t      result,
    output logic                   result_valid
);

    dtq_pkg::dtq_cmd_t  ctl;
    dtq_pkg::dtq_stat_t stat;

    dtq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (cmd.opcode),
        .stat   (stat),
        .busy   (busy),
        .ctl    (ctl)
    );

    dtq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctl          (ctl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

### src/dtq_checker.sv
// ----------------------------------------------------------------------------
// Delta timer queue checker
// Port-level checks on command acceptance and result beat sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire dtq_pkg::dtq_out_t result,
    input wire logic              result_valid
);

    logic accepted;

    assign accepted = start && !busy;

    a_no_beat_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> !result_valid)
        else $error("result beat in the cycle after a command was accepted");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("still busy while the final beat is shown");

    a_more_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> busy)
        else $error("idle while further beats are due");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != dtq_pkg::ST_EXPIRED)) |-> result.last)
        else $error("non-expiry beat not marked final");

endmodule

bind delta_timer_queue_core dtq_checker u_dtq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid)
);

`default_nettype wire

### tb/delta_timer_queue_core_tb.sv
// ----------------------------------------------------------------------------
// Delta timer queue core testbench
// Sends add, delete and tick commands over the start/busy handshake and checks
// every result beat against an in-bench model of the sorted delta queue. A
// short table of directed commands comes first. It covers the zero-expiry,
// re-add and not-queued rejects, a full queue that expires all at once, and the
// widest expiry. Random commands follow in phases with and without gaps between them.
// ----------------------------------------------------------------------------
module delta_timer_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLAN_ROWS    = 26;
    localparam int PHASE_BEATS  = 19;
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        dtq_pkg::dtq_in_t  beat;
        logic              pinned;
        dtq_pkg::dtq_out_t pin;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    dtq_pkg::dtq_in_t  cmd;
    dtq_pkg::dtq_out_t result;
    logic              result_valid;

    logic [dtq_pkg::HANDLE_W-1:0]   chain_handle [dtq_pkg::TIMERS];
    logic [dtq_pkg::DELTA_BITS-1:0] chain_delta [dtq_pkg::TIMERS];
    int                             chain_len;
    logic [dtq_pkg::NHANDLES-1:0]   armed;

    dtq_pkg::dtq_out_t awaited_events [$];
    dtq_pkg::dtq_out_t want;
    plan_row_t         plan [PLAN_ROWS];
    int                idle_pct [4] = '{0, 84, 0, 24};
    int                faults = 0;
    int                cycles = 0;

    delta_timer_queue_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid)
    );

    always #4 clk = ~clk;

    function automatic void note_event(logic [2:0] st, logic [dtq_pkg::HANDLE_W-1:0] h,
                                       logic fin, bit keep);
        dtq_pkg::dtq_out_t ev;
        ev.status     = st;
        ev.handle_out = h;
        ev.last       = fin;
        if (keep)
            awaited_events.push_back(ev);
    endfunction

    function automatic void drop_entry(int p);
        for (int j = p; j + 1 < chain_len; j++)
        begin
            chain_handle[j] = chain_handle[j + 1];
            chain_delta[j]  = chain_delta[j + 1];
        end
        chain_len--;
    endfunction

    function automatic void predict_timer_events(dtq_pkg::dtq_in_t b, bit keep);
        logic [dtq_pkg::DELTA_BITS-1:0] rest;
        logic [dtq_pkg::HANDLE_W-1:0]   h;
        logic                           fin;
        int                             i;
        int                             n;
        h = b.timer_handle;
        case (b.opcode)
            dtq_pkg::OP_ADD:
            begin
                rest = dtq_pkg::sat_delta(b.expiry_ticks);
                if (rest == '0 || armed[h])
                    note_event(dtq_pkg::ST_BAD_ADD, h, 1'b1, keep);
                else if (chain_len >= dtq_pkg::TIMERS)
                    note_event(dtq_pkg::ST_FULL, h, 1'b1, keep);
                else
                begin
                    i = 0;
                    while (i < chain_len && rest >= chain_delta[i])
                    begin
                        rest = rest - chain_delta[i];
                        i++;
                    end
                    if (i < chain_len)
                        chain_delta[i] = chain_delta[i] - rest;
                    for (int j = chain_len; j > i; j--)
                    begin
                        chain_handle[j] = chain_handle[j - 1];
                        chain_delta[j]  = chain_delta[j - 1];
                    end
                    chain_handle[i] = h;
                    chain_delta[i]  = rest;
                    chain_len++;
                    armed[h] = 1'b1;
                    note_event(dtq_pkg::ST_ADDED, h, 1'b1, keep);
                end
            end
            dtq_pkg::OP_DELETE:
            begin
                if (!armed[h])
                    note_event(dtq_pkg::ST_NOT_QUEUED, h, 1'b1, keep);
                else
                begin
                    i = 0;
                    while (i < chain_len && chain_handle[i] != h)
                        i++;
                    if (i < chain_len)
                    begin
                        if (i + 1 < chain_len)
                            chain_delta[i + 1] = chain_delta[i + 1] + chain_delta[i];
                        drop_entry(i);
                    end
                    armed[h] = 1'b0;
                    note_event(dtq_pkg::ST_DELETED, h, 1'b1, keep);
                end
            end
            dtq_pkg::OP_TICK:
            begin
                if (chain_len > 0 && chain_delta[0] != '0)
                    chain_delta[0] = chain_delta[0] - dtq_pkg::DELTA_BITS'(1);
                n = 0;
                while (chain_len > 0 && chain_delta[0] == '0 && n < dtq_pkg::NHANDLES)
                begin
                    h = chain_handle[0];
                    drop_entry(0);
                    armed[h] = 1'b0;
                    fin = !(chain_len > 0 && chain_delta[0] == '0
                            && n + 1 < dtq_pkg::NHANDLES);
                    note_event(dtq_pkg::ST_EXPIRED, h, fin, keep);
                    n++;
                end
                if (n == 0)
                    note_event(dtq_pkg::ST_TICK_NONE, '0, 1'b1, keep);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic plan_row_t plan_row(logic [1:0] op, int h,
                                           logic [dtq_pkg::EXP_W-1:0] e,
                                           logic pinned, logic [2:0] st, int hout);
        plan_row_t r;
        r.beat.opcode       = op;
        r.beat.timer_handle = h[dtq_pkg::HANDLE_W-1:0];
        r.beat.expiry_ticks = e;
        r.pinned            = pinned;
        r.pin.status        = st;
        r.pin.handle_out    = hout[dtq_pkg::HANDLE_W-1:0];
        r.pin.last          = 1'b1;
        return r;
    endfunction

    function automatic dtq_pkg::dtq_in_t random_beat();
        dtq_pkg::dtq_in_t b;
        int               pick;
        int               span;
        int               hpick;
        pick  = $urandom_range(99);
        hpick = $urandom_range(dtq_pkg::NHANDLES - 1);
        b.timer_handle = hpick[dtq_pkg::HANDLE_W-1:0];
        b.expiry_ticks = $urandom;
        if (pick < 40)
        begin
            b.opcode = dtq_pkg::OP_ADD;
            span = $urandom_range(19);
            if (span == 0)
                b.expiry_ticks = '0;
            else if (span == 1)
                b.expiry_ticks = '1;
            else if (span > 3)
                b.expiry_ticks = $urandom_range(6, 1);
        end
        else if (pick < 57)
            b.opcode = dtq_pkg::OP_DELETE;
        else if (pick < 97)
            b.opcode = dtq_pkg::OP_TICK;
        else
            b.opcode = dtq_pkg::OP_NONE;
        return b;
    endfunction

    task automatic issue_beat(dtq_pkg::dtq_in_t b, logic pinned, dtq_pkg::dtq_out_t pin);
        start <= 1'b1;
        cmd   <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_timer_events(b, !pinned);
        if (pinned)
            awaited_events.push_back(pin);
    endtask

    task automatic rest_between(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < pct)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (awaited_events.size() == 0)
            begin
                $error("unexpected result beat: status %0d handle %0d last %0d",
                       result.status, result.handle_out, result.last);
                faults++;
            end
            else
            begin
                want = awaited_events.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    faults++;
                end
                if (result.handle_out !== want.handle_out)
                begin
                    $error("handle_out: expected %0d, got %0d", want.handle_out,
                           result.handle_out);
                    faults++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("delta_timer_queue_core_tb: errors");
            $finish;
        end
    end

    initial
    begin
        dtq_pkg::dtq_in_t b;
        int               sent;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        chain_len = 0;
        armed     = '0;

        plan[0]  = plan_row(dtq_pkg::OP_TICK, 9, 32'h0, 1'b1, dtq_pkg::ST_TICK_NONE, 0);
        plan[1]  = plan_row(dtq_pkg::OP_DELETE, 0, 32'h0, 1'b1, dtq_pkg::ST_NOT_QUEUED, 0);
        plan[2]  = plan_row(dtq_pkg::OP_ADD, 0, 32'h0, 1'b1, dtq_pkg::ST_BAD_ADD, 0);
        plan[3]  = plan_row(dtq_pkg::OP_ADD, 15, 32'h1, 1'b1, dtq_pkg::ST_ADDED, 15);
        plan[4]  = plan_row(dtq_pkg::OP_ADD, 15, 32'h7, 1'b1, dtq_pkg::ST_BAD_ADD, 15);
        for (int k = 0; k < dtq_pkg::NHANDLES - 1; k++)
            plan[5 + k] = plan_row(dtq_pkg::OP_ADD, k, 32'h1, 1'b0, dtq_pkg::ST_ADDED, k);
        plan[20] = plan_row(dtq_pkg::OP_TICK, 0, 32'hFFFF_FFFF, 1'b0, dtq_pkg::ST_ADDED, 0);
        plan[21] = plan_row(dtq_pkg::OP_ADD, 7, 32'hFFFF_FFFF, 1'b1, dtq_pkg::ST_ADDED, 7);
        plan[22] = plan_row(dtq_pkg::OP_ADD, 8, 32'h3, 1'b0, dtq_pkg::ST_ADDED, 0);
        plan[23] = plan_row(dtq_pkg::OP_DELETE, 8, 32'h0, 1'b0, dtq_pkg::ST_ADDED, 0);
        plan[24] = plan_row(dtq_pkg::OP_NONE, 9, 32'h5555_AAAA, 1'b0, dtq_pkg::ST_ADDED, 0);
        plan[25] = plan_row(dtq_pkg::OP_TICK, 3, 32'h0, 1'b0, dtq_pkg::ST_ADDED, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
            issue_beat(plan[r].beat, plan[r].pinned, plan[r].pin);

        for (int phase = 0; phase < 4; phase++)
        begin
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                b = random_beat();
                issue_beat(b, 1'b0, '0);
                rest_between(idle_pct[phase]);
                if (b.opcode != dtq_pkg::OP_NONE)
                    sent++;
            end
        end

        start <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("delta_timer_queue_core_tb: clean");
        else
            $display("delta_timer_queue_core_tb: errors");
        $finish;
    end

endmodule
